// ===== src/fenwick_select_kth_remaining_top_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef FENWICK_SELECT_KTH_REMAINING_TOP_MACROS_SVH
`define FENWICK_SELECT_KTH_REMAINING_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define FWSEL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define FWSEL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fwsel_pkg.sv =====
// Types, widths and codes shared by the Fenwick select block.
package fwsel_pkg;

	localparam int OP_W      = 2;
	localparam int POS_W     = 11;
	localparam int DELTA_W   = 16;
	localparam int RANK_W    = 11;
	localparam int VALUE_W   = 32;
	localparam int SIZE_W    = 11;

	localparam int MAX_POSITIONS_DEF = 1024;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// Operation codes of a request.
	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_PREFIX = 2'd1;
	localparam logic [OP_W-1:0] OP_SELECT = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	// Request beat.
	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic [POS_W-1:0]          position;
		logic signed [DELTA_W-1:0] delta;
		logic [RANK_W-1:0]         rank;
	} fwsel_req_t;

	// Result beat.
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      error;
	} fwsel_res_t;

	// What the result register is loaded with.
	typedef enum logic [1:0] {
		RES_ZERO = 2'd0,
		RES_ERR  = 2'd1,
		RES_SUM  = 2'd2,
		RES_POS  = 2'd3
	} fwsel_res_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic           load;
		logic           clr_we;
		logic           idx_pos;
		logic           idx_n;
		logic           add_wr;
		logic           pre_acc;
		logic           sel_init;
		logic           sel_acc;
		logic           sel_fin;
		logic           emit;
		fwsel_res_sel_t res_sel;
	} fwsel_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            pos_bad;
		logic            add_live;
		logic            pre_live;
		logic            rank_bad;
		logic            step_last;
		logic            clear_last;
	} fwsel_status_t;

endpackage

// ===== src/fwsel_datapath.sv =====
// Datapath: node memory, walk index, accumulator, descent registers and result register.
module fwsel_datapath import fwsel_pkg::*; #(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fwsel_req_t          req,
	input  logic                cfg_we,
	input  logic [SIZE_W-1:0]   cfg_data,
	input  fwsel_cmd_t          cmd,
	output fwsel_status_t       status,
	output logic                done,
	output fwsel_res_t          result
);

	localparam int IW = $clog2(MAX_POSITIONS + 1);
	localparam int XW = IW + 1;
	localparam int AW = $clog2(MAX_POSITIONS);
	localparam int CW = (IW > SIZE_W) ? IW : SIZE_W;
	localparam logic [IW-1:0] TOP_STEP = IW'(1) << (IW - 1);
	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_POSITIONS - 1);

	logic [SIZE_W-1:0]  size_q;
	logic [OP_W-1:0]    op_q;
	logic [POS_W-1:0]   position_q;
	logic [RANK_W-1:0]  rank_q;
	logic [VALUE_W-1:0] amount_q;
	logic [IW-1:0]      n_q;
	logic [XW-1:0]      idx_q;
	logic [XW-1:0]      pos_q;
	logic [IW-1:0]      step_q;
	logic [VALUE_W-1:0] acc_q;
	logic [AW-1:0]      clr_q;
	logic [VALUE_W-1:0] rdata_q;
	logic               done_q;
	logic [VALUE_W-1:0] value_q;
	logic               error_q;

	logic [VALUE_W-1:0] mem [MAX_POSITIONS];

	logic [CW-1:0]      size_c;
	logic [CW-1:0]      max_c;
	logic [CW-1:0]      n_c;
	logic [XW-1:0]      lowbit;
	logic [AW-1:0]      mem_addr;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [VALUE_W-1:0] mem_wd;
	logic [VALUE_W-1:0] trial;
	logic signed [VALUE_W:0] rank_x;
	logic               total_below;
	logic               trial_below;
	logic               in_range;
	logic               sel_take;
	logic [XW-1:0]      pos_nx;
	logic [IW-1:0]      step_nx;

	// Active size is the register clamped to MAX_POSITIONS.
	always_comb begin
		size_c = CW'(size_q);
		max_c  = CW'(MAX_POSITIONS);
		n_c    = (size_c > max_c) ? max_c : size_c;
	end

	// Walk arithmetic: lowest set bit, node address, trial sum and rank compares.
	always_comb begin
		lowbit      = idx_q & (~idx_q + XW'(1));
		mem_addr    = AW'(idx_q - XW'(1));
		trial       = acc_q + rdata_q;
		rank_x      = $signed({{(VALUE_W + 1 - RANK_W){1'b0}}, rank_q});
		total_below = $signed({acc_q[VALUE_W-1], acc_q}) < rank_x;
		trial_below = $signed({trial[VALUE_W-1], trial}) < rank_x;
		in_range    = idx_q <= XW'(n_q);
		sel_take    = in_range && trial_below;
		pos_nx      = sel_take ? idx_q : pos_q;
		step_nx     = step_q >> 1;
	end

	// Memory write port is shared by the clearing pass and the update walk.
	always_comb begin
		mem_we = cmd.clr_we | cmd.add_wr;
		mem_wa = cmd.clr_we ? clr_q : mem_addr;
		mem_wd = cmd.clr_we ? '0 : (rdata_q + amount_q);
	end

	// Status toward the controller.
	always_comb begin
		status.op         = op_q;
		status.pos_bad    = (position_q == '0) || (CW'(position_q) > CW'(n_q));
		status.add_live   = in_range;
		status.pre_live   = idx_q != '0;
		status.rank_bad   = (rank_q == '0) || (n_q == '0) || total_below;
		status.step_last  = step_q == IW'(1);
		status.clear_last = clr_q == CLR_LAST;
	end

	// Node memory with registered read data; the node at the walk index is read every cycle.
	always_ff @(posedge clk) begin
		rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// Size register, clearing counter and done flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			if (cmd.clr_we) begin
				clr_q <= clr_q + AW'(1);
			end
			done_q <= cmd.emit;
		end
	end

	// Request capture and walk registers; the controller issues one command at a time.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= req.op;
			position_q <= req.position;
			rank_q     <= req.rank;
			amount_q   <= {{(VALUE_W - DELTA_W){req.delta[DELTA_W-1]}}, req.delta};
			n_q        <= IW'(n_c);
		end else if (cmd.idx_pos) begin
			idx_q <= XW'(position_q);
			acc_q <= '0;
		end else if (cmd.idx_n) begin
			idx_q <= XW'(n_q);
			acc_q <= '0;
		end else if (cmd.add_wr) begin
			idx_q <= idx_q + lowbit;
		end else if (cmd.pre_acc) begin
			acc_q <= trial;
			idx_q <= idx_q - lowbit;
		end else if (cmd.sel_init) begin
			pos_q  <= '0;
			acc_q  <= '0;
			step_q <= TOP_STEP;
			idx_q  <= XW'(TOP_STEP);
		end else if (cmd.sel_acc) begin
			pos_q  <= pos_nx;
			step_q <= step_nx;
			idx_q  <= pos_nx + XW'(step_nx);
			if (sel_take) begin
				acc_q <= trial;
			end
		end else if (cmd.sel_fin) begin
			idx_q    <= pos_q + XW'(1);
			amount_q <= '1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.res_sel)
				RES_ZERO: begin
					value_q <= '0;
					error_q <= 1'b0;
				end
				RES_ERR: begin
					value_q <= '0;
					error_q <= 1'b1;
				end
				RES_SUM: begin
					value_q <= acc_q;
					error_q <= 1'b0;
				end
				RES_POS: begin
					value_q <= VALUE_W'(pos_q + XW'(1));
					error_q <= 1'b0;
				end
				default: begin
					value_q <= '0;
					error_q <= 1'b1;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign result.value = value_q;
	assign result.error = error_q;

endmodule

// ===== src/fwsel_ctrl.sv =====
// Controller state machine: clearing pass, request decode and the tree walks.
module fwsel_ctrl import fwsel_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  fwsel_status_t status,
	output logic          busy,
	output fwsel_cmd_t    cmd
);

	typedef enum logic [12:0] {
		S_CLEAR   = 13'b0000000000001,
		S_IDLE    = 13'b0000000000010,
		S_DECODE  = 13'b0000000000100,
		S_ADD_CHK = 13'b0000000001000,
		S_ADD_WR  = 13'b0000000010000,
		S_PRE_CHK = 13'b0000000100000,
		S_PRE_ACC = 13'b0000001000000,
		S_TOT_CHK = 13'b0000010000000,
		S_TOT_ACC = 13'b0000100000000,
		S_RANK    = 13'b0001000000000,
		S_SEL_RD  = 13'b0010000000000,
		S_SEL_ACC = 13'b0100000000000,
		S_SEL_FIN = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.res_sel = RES_ZERO;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (status.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.op)
					OP_ADD: begin
						if (status.pos_bad) begin
							cmd.emit    = 1'b1;
							cmd.res_sel = RES_ERR;
							state_d     = S_IDLE;
						end else begin
							cmd.idx_pos = 1'b1;
							state_d     = S_ADD_CHK;
						end
					end
					OP_PREFIX: begin
						if (status.pos_bad) begin
							cmd.emit    = 1'b1;
							cmd.res_sel = RES_ERR;
							state_d     = S_IDLE;
						end else begin
							cmd.idx_pos = 1'b1;
							state_d     = S_PRE_CHK;
						end
					end
					OP_SELECT: begin
						cmd.idx_n = 1'b1;
						state_d   = S_TOT_CHK;
					end
					default: begin
						cmd.emit    = 1'b1;
						cmd.res_sel = RES_ERR;
						state_d     = S_IDLE;
					end
				endcase
			end
			// Update walk upward; the node read happens in this state.
			S_ADD_CHK: begin
				if (status.add_live) begin
					state_d = S_ADD_WR;
				end else begin
					cmd.emit    = 1'b1;
					cmd.res_sel = (status.op == OP_SELECT) ? RES_POS : RES_ZERO;
					state_d     = S_IDLE;
				end
			end
			S_ADD_WR: begin
				cmd.add_wr = 1'b1;
				state_d    = S_ADD_CHK;
			end
			// Prefix walk downward.
			S_PRE_CHK: begin
				if (status.pre_live) begin
					state_d = S_PRE_ACC;
				end else begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_SUM;
					state_d     = S_IDLE;
				end
			end
			S_PRE_ACC: begin
				cmd.pre_acc = 1'b1;
				state_d     = S_PRE_CHK;
			end
			// Total over the active range before a select.
			S_TOT_CHK: begin
				state_d = status.pre_live ? S_TOT_ACC : S_RANK;
			end
			S_TOT_ACC: begin
				cmd.pre_acc = 1'b1;
				state_d     = S_TOT_CHK;
			end
			S_RANK: begin
				if (status.rank_bad) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_ERR;
					state_d     = S_IDLE;
				end else begin
					cmd.sel_init = 1'b1;
					state_d      = S_SEL_RD;
				end
			end
			// Descent: one read and one decision per step.
			S_SEL_RD: begin
				state_d = S_SEL_ACC;
			end
			S_SEL_ACC: begin
				cmd.sel_acc = 1'b1;
				state_d     = status.step_last ? S_SEL_FIN : S_SEL_RD;
			end
			S_SEL_FIN: begin
				cmd.sel_fin = 1'b1;
				state_d     = S_ADD_CHK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

endmodule

// ===== src/fenwick_select_kth_remaining_top.sv =====
// Fenwick tree order-statistic block: prefix sums, point updates and select-and-remove.
// A request beat is taken when start is high and busy is low. After reset the node
// memory is cleared one entry a cycle, while busy stays high, before the first request.
// Every node visit has a state that reads the node from the single-read-port memory and
// a state that uses it. A select runs the total walk, the descent, then the removal walk;
// a request rejected for its position or op is answered from the decode state, and a
// select rejected for its rank is answered after the total walk. The result beat shows
// on result for one cycle with done high and cannot be held off; busy is low in that
// same cycle, so the next request may be taken at once.
module fenwick_select_kth_remaining_top import fwsel_pkg::*; #(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fwsel_req_t        req,
	output logic              done,
	output fwsel_res_t        result,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_data
);

	fwsel_cmd_t    cmd;
	fwsel_status_t status;

	// Sequencer.
	fwsel_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Node memory and arithmetic.
	fwsel_datapath #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.done     (done),
		.result   (result)
	);

endmodule

// ===== src/fwsel_checker.sv =====
// Port-level checks of the Fenwick select block, bound to the top level.
`include "fenwick_select_kth_remaining_top_macros.svh"

module fwsel_checker import fwsel_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input fwsel_req_t req,
	input logic       done,
	input fwsel_res_t result
);

	// An accepted request makes the block busy in the next cycle.
	`FWSEL_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request taken but block not busy")

	// A result beat is shown only once the block is free again.
	`FWSEL_ASSERT_NOW(a_done_idle, done, !busy, "result shown while block busy")

	// A rejected request always reports value zero.
	`FWSEL_ASSERT_NOW(a_err_zero, done && result.error, result.value == '0, "error with nonzero value")

	// An unused op is rejected from the decode state, with done and error high.
	`FWSEL_ASSERT_NOW(a_bad_op, start && !busy && req.op == OP_NONE, ##2 (done && result.error), "unused op not rejected")

endmodule

bind fenwick_select_kth_remaining_top fwsel_checker u_fwsel_checker (.*);

// ===== tb/sv/tb.sv =====
// Testbench for the Fenwick select block: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb;
	import fwsel_pkg::*;

	localparam int MAXP         = MAX_POSITIONS_DEF;
	localparam int LIMIT_CYCLES = 400000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	fwsel_req_t        req;
	logic              done;
	fwsel_res_t        result;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_data;

	// Predictor state: node sums and the size register as the block should hold them.
	logic [31:0]       node_sums [1:MAXP];
	logic [SIZE_W-1:0] size_shadow;

	fwsel_res_t pending_results [$];
	int         fail_count;
	int         cycle_count;
	int         sender_idle_pct;

	fenwick_select_kth_remaining_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Free-running clock, 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t timeout after %0d cycles", $time, cycle_count);
			$display("FAIL fenwick_select_kth_remaining_top");
			$finish;
		end
	end

	// Number of positions in use; an oversized register acts as the maximum.
	function automatic int unsigned active_positions();
		return (size_shadow > MAXP) ? MAXP : int'(size_shadow);
	endfunction

	// Point update: walk up the tree while within the active size.
	function automatic void node_add(input int unsigned pos, input logic [31:0] amount,
			input int unsigned n);
		int unsigned i;
		for (i = pos; i >= 1 && i <= n; i += (i & (~i + 1)))
			node_sums[i] += amount;
	endfunction

	// Prefix sum: walk down the tree, reading nodes as they stand.
	function automatic logic [31:0] node_prefix(input int unsigned pos);
		logic [31:0] sum;
		int unsigned i;
		sum = '0;
		i = pos;
		while (i != 0) begin
			sum += node_sums[i];
			i -= (i & (~i + 1));
		end
		return sum;
	endfunction

	// Expected result of one request; updates the predicted tree as the block should.
	function automatic fwsel_res_t predict_request(input fwsel_req_t r);
		fwsel_res_t  res;
		int unsigned n;
		int unsigned stride;
		int unsigned pos;
		int unsigned nxt;
		logic [31:0] acc;
		logic [31:0] trial;
		logic [31:0] total;
		n = active_positions();
		res.value = '0;
		res.error = 1'b0;
		case (r.op)
			OP_ADD, OP_PREFIX: begin
				if (r.position == 0 || r.position > n)
					res.error = 1'b1;
				else if (r.op == OP_ADD)
					node_add(r.position, {{16{r.delta[DELTA_W-1]}}, r.delta}, n);
				else
					res.value = node_prefix(r.position);
			end
			OP_SELECT: begin
				total = node_prefix(n);
				if (n == 0 || r.rank == 0 || int'(r.rank) > $signed(total)) begin
					res.error = 1'b1;
				end else begin
					// Descent: keep the largest tested prefix that stays below the rank.
					stride = 1;
					while (stride * 2 <= MAXP)
						stride *= 2;
					pos = 0;
					acc = '0;
					for (; stride != 0; stride >>= 1) begin
						nxt = pos + stride;
						if (nxt <= n) begin
							trial = acc + node_sums[nxt];
							if ($signed(trial) < int'(r.rank)) begin
								pos = nxt;
								acc = trial;
							end
						end
					end
					res.value = pos + 1;
					node_add(pos + 1, 32'hFFFF_FFFF, n);
				end
			end
			default: res.error = 1'b1;
		endcase
		return res;
	endfunction

	function automatic fwsel_req_t make_req(input logic [OP_W-1:0] op,
			input int unsigned pos, input logic [DELTA_W-1:0] delta, input int unsigned rnk);
		fwsel_req_t r;
		r.op       = op;
		r.position = pos[POS_W-1:0];
		r.delta    = delta;
		r.rank     = rnk[RANK_W-1:0];
		return r;
	endfunction

	// Sends one request beat, with a random hold-off first, and records its expected result.
	task automatic send_request(input fwsel_req_t r);
		int gap;
		gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 40) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy);
		pending_results = {pending_results, predict_request(r)};
	endtask

	// Lets every expected result arrive and the block go idle.
	task automatic wait_settled();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] val);
		wait_settled();
		cfg_we   <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		cfg_we      <= 1'b0;
		size_shadow  = val;
	endtask

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		fwsel_res_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result beat: expected none, actual value=%0d error=%0b",
					$time, result.value, result.error);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.value !== want.value) begin
					$display("%0t value mismatch: expected %0d, actual %0d",
						$time, want.value, result.value);
					fail_count++;
				end
				if (result.error !== want.error) begin
					$display("%0t error mismatch: expected %0b, actual %0b",
						$time, want.error, result.error);
					fail_count++;
				end
			end
		end
	end

	// Field extremes, every operation and the rejection cases at the reset size.
	task automatic test_field_extremes();
		send_request(make_req(OP_ADD, 1, 16'sd1, 2047));
		send_request(make_req(OP_ADD, 1024, 16'h7FFF, 0));
		send_request(make_req(OP_ADD, 512, 16'h8000, 0));
		send_request(make_req(OP_ADD, 1023, 16'hFFFF, 1024));
		send_request(make_req(OP_ADD, 0, 16'sd5, 0));
		send_request(make_req(OP_ADD, 2047, 16'sd5, 0));
		send_request(make_req(OP_PREFIX, 1024, 16'hFFFF, 2047));
		send_request(make_req(OP_PREFIX, 1025, 0, 0));
		send_request(make_req(OP_PREFIX, 1, 0, 0));
		send_request(make_req(OP_SELECT, 1, 0, 0));
		send_request(make_req(OP_SELECT, 0, 0, 2047));
		// Total is negative here, so any rank is too large.
		send_request(make_req(OP_SELECT, 2047, 16'hFFFF, 1));
		send_request(make_req(OP_NONE, 2047, 16'hFFFF, 2047));
		// Negative counts in the tree: the descent no longer finds a true order statistic.
		send_request(make_req(OP_ADD, 700, 16'sd5, 0));
		send_request(make_req(OP_SELECT, 0, 0, 1));
	endtask

	// Size register at zero, above the maximum and at one.
	task automatic test_size_extremes();
		write_size(11'd0);
		send_request(make_req(OP_ADD, 1, 16'sd1, 0));
		send_request(make_req(OP_PREFIX, 1, 0, 0));
		send_request(make_req(OP_SELECT, 0, 0, 1));
		write_size(11'd2047);
		send_request(make_req(OP_ADD, 1024, 16'sd3, 0));
		send_request(make_req(OP_PREFIX, 1024, 0, 0));
		write_size(11'd1);
		send_request(make_req(OP_SELECT, 1, 0, 1));
		send_request(make_req(OP_PREFIX, 2, 0, 0));
	endtask

	// Shrinking the size after loading leaves the upper nodes as they are.
	task automatic test_size_shrink();
		int unsigned p;
		write_size(11'd4);
		for (p = 1; p <= 4; p++)
			send_request(make_req(OP_ADD, p, 16'sd1, 0));
		write_size(11'd2);
		send_request(make_req(OP_SELECT, 0, 0, 2));
		send_request(make_req(OP_PREFIX, 2, 0, 0));
		send_request(make_req(OP_ADD, 3, 16'sd1, 0));
	endtask

	// Random phases: load ones at sizes up to 100, then selects most often, with some queries, adds and noise.
	task automatic test_random_phases();
		int          phase_sizes [8] = '{7, 16, 33, 64, 1, 2047, 100, 3};
		int          idle_pcts   [4] = '{0, 52, 0, 18};
		int          ph;
		int          k;
		int          pick;
		int unsigned n;
		int unsigned p;
		int          total;
		for (ph = 0; ph < 8; ph++) begin
			write_size(phase_sizes[ph][SIZE_W-1:0]);
			sender_idle_pct = idle_pcts[ph % 4];
			n = active_positions();
			if (n <= 100)
				for (p = 1; p <= n; p++)
					send_request(make_req(OP_ADD, p, 16'sd1, $urandom_range(0, 2047)));
			for (k = 0; k < 55; k++) begin
				pick  = $urandom_range(0, 99);
				total = $signed(node_prefix(n));
				if (pick < 45 && total >= 1)
					send_request(make_req(OP_SELECT, $urandom_range(0, 2047), 16'($urandom),
						$urandom_range(1, (total > 2047) ? 2047 : total)));
				else if (pick < 45)
					send_request(make_req(OP_ADD, $urandom_range(1, n), 16'sd1,
						$urandom_range(0, 2047)));
				else if (pick < 65)
					send_request(make_req(OP_PREFIX, $urandom_range(1, n), 16'($urandom),
						$urandom_range(0, 2047)));
				else if (pick < 80)
					send_request(make_req(OP_ADD, $urandom_range(1, n),
						16'($signed($urandom_range(0, 4)) - 1), $urandom_range(0, 2047)));
				else
					send_request(make_req(OP_W'($urandom_range(0, 3)),
						$urandom_range(0, 2047), 16'($urandom), $urandom_range(0, 2047)));
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		req             = '0;
		cfg_we          = 1'b0;
		cfg_data        = '0;
		fail_count      = 0;
		sender_idle_pct = 0;
		size_shadow     = SIZE_RESET;
		for (int i = 1; i <= MAXP; i++)
			node_sums[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_size_extremes();
		test_size_shrink();
		test_random_phases();
		wait_settled();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS fenwick_select_kth_remaining_top");
		else
			$display("FAIL fenwick_select_kth_remaining_top");
		$finish;
	end

endmodule
